[hw/rtl/constant_rate_request_pacer_assert.svh]
// ---------------------------------------------------------------------------
// Pacer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_RATE_REQUEST_PACER_ASSERT_SVH
`define CONSTANT_RATE_REQUEST_PACER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define CRRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define CRRP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRRP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[hw/rtl/crrp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request pacer package
// Field widths, event and register codes, and beat structures.
// ---------------------------------------------------------------------------
package crrp_pkg;

  // port field widths
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 10;
  localparam int IV_W     = 40;
  localparam int DEPTH_W  = 8;
  localparam int CFG_IDX_W = 2;

  // status codes above this are errors
  localparam logic [STATUS_W-1:0] STATUS_ERR_LIMIT = STATUS_W'(399);

  // register reset values
  localparam logic [IV_W-1:0]    IV_RESET    = IV_W'(256);
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(1);

  // event codes
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_SEND  = 2'd1,
    REQ_DONE  = 2'd2
  } req_type_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIPELINE_DEPTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ALL     = 2'd3;

  typedef struct packed {
    logic                rate_enabled;
    logic [IV_W-1:0]     send_interval;
    logic [DEPTH_W-1:0]  pipeline_depth;
    logic                record_all;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [TIME_W-1:0]   now_us;
    logic [STATUS_W-1:0] resp_status;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   wait_us;
    logic                go_ahead;
    logic [TIME_W-1:0]   corrected_latency;
    logic [TIME_W-1:0]   uncorrected_latency;
    logic                latency_valid;
    logic                latency_negative;
    logic                status_error;
    logic                batch_done;
  } result_t;

  // product recalculation status
  typedef struct packed {
    logic busy;
    logic done;
  } recalc_stat_t;

endpackage

[hw/rtl/crrp_recalc.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Schedule product recalculation
// Shift-add multiplier, one count bit per cycle, rebuilding the three
// count-times-interval products after a new interval is written.
// ---------------------------------------------------------------------------
module crrp_recalc #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [crrp_pkg::IV_W-1:0]             mcand_in,
  input  logic [2:0][COUNT_BITS-1:0]            cnt_in,
  output crrp_pkg::recalc_stat_t                stat,
  output logic [2:0][COUNT_BITS+crrp_pkg::IV_W-1:0] prod
);
  import crrp_pkg::*;

  localparam int PW = COUNT_BITS + IV_W;
  localparam int SW = $clog2(COUNT_BITS + 1);

  logic [2:0][COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [2:0][PW-1:0]         acc_r, acc_nxt;
  logic [PW-1:0]              mcand_r, mcand_nxt;
  logic [SW-1:0]              step_r, step_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  // one partial product per lane per cycle
  always_comb begin
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    step_nxt  = step_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      cnt_nxt   = cnt_in;
      acc_nxt   = '0;
      mcand_nxt = PW'(mcand_in);
      step_nxt  = SW'(COUNT_BITS);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        if (cnt_r[i][0]) acc_nxt[i] = acc_r[i] + mcand_r;
        cnt_nxt[i] = cnt_r[i] >> 1;
      end
      mcand_nxt = mcand_r << 1;
      step_nxt  = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    cnt_r   <= cnt_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;

endmodule

[hw/rtl/crrp_core.sv]
`timescale 1ns / 1ps
`include "constant_rate_request_pacer_assert.svh"
// ---------------------------------------------------------------------------
// Pacer core
// Connection state and the single-pass event logic. The schedule products
// (count times interval) are kept up to date incrementally, so each event
// needs only a shift, a saturating add and a compare.
// ---------------------------------------------------------------------------
module crrp_core #(
  parameter int TIME_BITS  = 48,
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      fire,
  input  crrp_pkg::item_t                           item,
  input  crrp_pkg::cfg_t                            cfg,
  input  crrp_pkg::recalc_stat_t                    recalc_stat,
  input  logic [2:0][COUNT_BITS+crrp_pkg::IV_W-1:0] recalc_prod,
  output logic [2:0][COUNT_BITS-1:0]                counts,
  output crrp_pkg::result_t                         res
);
  import crrp_pkg::*;

  localparam int TW = TIME_BITS;
  localparam int CW = COUNT_BITS;
  localparam int PW = COUNT_BITS + IV_W;
  localparam int XW = (PW > TW) ? PW : TW;

  // floor(p / 2^shift), saturated at the top of the time range
  function automatic logic [TW-1:0] scale_sat(input logic [PW-1:0] p, input logic half);
    logic [PW-1:0] q;
    logic [TW-1:0] tmax;
    tmax = '1;
    q    = half ? (p >> (FRAC_BITS + 1)) : (p >> FRAC_BITS);
    if (XW'(q) > XW'(tmax)) return tmax;
    return TW'(q);
  endfunction

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // connection state
  logic [TW-1:0]      conn_start_r, conn_start_nxt;
  logic [CW-1:0]      done_count_r, done_count_nxt;
  logic               on_sched_r, on_sched_nxt;
  logic [TW-1:0]      catch_start_r, catch_start_nxt;
  logic [CW-1:0]      since_r, since_nxt;
  logic [CW-1:0]      done_at_batch_r, done_at_batch_nxt;
  logic [TW-1:0]      batch_start_r, batch_start_nxt;
  logic               batch_pending_r, batch_pending_nxt;
  logic [DEPTH_W-1:0] pending_r, pending_nxt;
  // done_count, since-catch-up count and batch-start count times interval
  logic [PW-1:0]      prod_done_r, prod_done_nxt;
  logic [PW-1:0]      prod_since_r, prod_since_nxt;
  logic [PW-1:0]      prod_batch_r, prod_batch_nxt;

  logic [TW-1:0] now;
  logic [PW-1:0] iv_ext;
  logic [TW-1:0] due_sched, due_catch, exp_rate;

  assign now    = TW'(item.now_us);
  assign iv_ext = PW'(cfg.send_interval);

  assign due_sched = sat_add(conn_start_r, scale_sat(prod_done_r, 1'b0));
  assign due_catch = sat_add(catch_start_r, scale_sat(prod_since_r, 1'b1));
  assign exp_rate  = sat_add(conn_start_r, scale_sat(prod_batch_r, 1'b0));

  // event decode and next state
  always_comb begin
    logic          go;
    logic [TW-1:0] due;
    logic [TW-1:0] exp_time;
    logic [TW-1:0] corr;
    logic [TW-1:0] unc;
    logic [DEPTH_W-1:0] pend_dec;

    conn_start_nxt    = conn_start_r;
    done_count_nxt    = done_count_r;
    on_sched_nxt      = on_sched_r;
    catch_start_nxt   = catch_start_r;
    since_nxt         = since_r;
    done_at_batch_nxt = done_at_batch_r;
    batch_start_nxt   = batch_start_r;
    batch_pending_nxt = batch_pending_r;
    pending_nxt       = pending_r;
    prod_done_nxt     = prod_done_r;
    prod_since_nxt    = prod_since_r;
    prod_batch_nxt    = prod_batch_r;
    res               = '0;
    go                = 1'b1;
    due               = '0;
    exp_time          = '0;
    corr              = '0;
    unc               = '0;
    pend_dec          = '0;

    if (fire) begin
      case (item.req_type)
        REQ_START: begin
          conn_start_nxt = now;
        end
        REQ_SEND: begin
          if (cfg.rate_enabled) begin
            if (due_sched > now) begin
              on_sched_nxt = 1'b1;
              go           = 1'b0;
              due          = due_sched;
            end else if (on_sched_r) begin
              // fell behind just now: catch-up schedule starts here
              on_sched_nxt    = 1'b0;
              catch_start_nxt = now;
              since_nxt       = '0;
              prod_since_nxt  = '0;
            end else if (due_catch > now) begin
              go  = 1'b0;
              due = due_catch;
            end
          end
          if (go) begin
            if (!batch_pending_r) begin
              batch_start_nxt   = now;
              done_at_batch_nxt = done_count_r;
              prod_batch_nxt    = prod_done_r;
              batch_pending_nxt = 1'b1;
            end
            pending_nxt = (cfg.pipeline_depth == '0) ? DEPTH_W'(1) : cfg.pipeline_depth;
            res.go_ahead = 1'b1;
          end else begin
            res.wait_us = TIME_W'(due - now);
          end
        end
        REQ_DONE: begin
          res.status_error = item.resp_status > STATUS_ERR_LIMIT;
          // counts wrap, products restart at zero with them
          done_count_nxt = done_count_r + CW'(1);
          prod_done_nxt  = (done_count_r == '1) ? '0 : prod_done_r + iv_ext;
          since_nxt      = since_r + CW'(1);
          prod_since_nxt = (since_r == '1) ? '0 : prod_since_r + iv_ext;
          exp_time = cfg.rate_enabled ? exp_rate : batch_start_r;
          if (now >= exp_time) begin
            corr = now - exp_time;
          end else begin
            res.latency_negative = 1'b1;
          end
          if (now >= batch_start_r) unc = now - batch_start_r;
          if (pending_r != '0) begin
            pend_dec    = pending_r - DEPTH_W'(1);
            pending_nxt = pend_dec;
            if (pend_dec == '0) begin
              batch_pending_nxt = 1'b0;
              res.batch_done    = 1'b1;
            end
          end
          res.corrected_latency   = TIME_W'(corr);
          res.uncorrected_latency = TIME_W'(unc);
          res.latency_valid       = cfg.record_all || !batch_pending_nxt;
        end
        default: begin
        end
      endcase
    end

    // rebuilt products after an interval write
    if (recalc_stat.done) begin
      prod_done_nxt  = recalc_prod[0];
      prod_since_nxt = recalc_prod[1];
      prod_batch_nxt = recalc_prod[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_start_r    <= '0;
      done_count_r    <= '0;
      on_sched_r      <= 1'b1;
      catch_start_r   <= '0;
      since_r         <= '0;
      done_at_batch_r <= '0;
      batch_start_r   <= '0;
      batch_pending_r <= 1'b0;
      pending_r       <= '0;
      prod_done_r     <= '0;
      prod_since_r    <= '0;
      prod_batch_r    <= '0;
    end else begin
      conn_start_r    <= conn_start_nxt;
      done_count_r    <= done_count_nxt;
      on_sched_r      <= on_sched_nxt;
      catch_start_r   <= catch_start_nxt;
      since_r         <= since_nxt;
      done_at_batch_r <= done_at_batch_nxt;
      batch_start_r   <= batch_start_nxt;
      batch_pending_r <= batch_pending_nxt;
      pending_r       <= pending_nxt;
      prod_done_r     <= prod_done_nxt;
      prod_since_r    <= prod_since_nxt;
      prod_batch_r    <= prod_batch_nxt;
    end
  end

  // counts handed to the recalculation unit, same lane order as products
  assign counts = {done_at_batch_r, since_r, done_count_r};

  // checks
  `CRRP_ASSERT(a_pending_matches, clk, rst_n, batch_pending_r == (pending_r != '0), "batch pending flag out of step with count")
  `CRRP_ASSERT(a_done_is_recorded, clk, rst_n, fire && res.batch_done |-> res.latency_valid, "batch end without latency record")
  `CRRP_ASSERT(a_send_no_wait, clk, rst_n, fire && res.go_ahead |-> res.wait_us == '0, "send granted with a wait")
  `CRRP_ASSERT_NEVER(a_recalc_idle, clk, rst_n, recalc_stat.done && fire, "products reloaded while a beat is at work")

endmodule

[hw/rtl/constant_rate_request_pacer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Constant-rate request pacer
// Per-connection send pacing with latency correction for late batches.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : one event beat (start, send query, response complete) with time.
//   out_*  : exactly one result beat per event, in order.
//   cfg_*  : register writes, taken at once; user must write only while no beat is in flight (unenforced).
// Path: a beat accepted into the input register moves on to the result
//   register, which drives out_*, once that register is free.
// Throughput: one event per cycle unless stalled or rebuilding; an input
//   register and a result register part the channels, so a stalled receiver
//   holds the result while the next event still enters the input register.
// Writing send_interval starts a rebuild of the schedule products in a
//   shift-add unit, one count bit per cycle: in_ready stays low until the
//   rebuild is done.
// Reset (rst_n low at a clock edge) clears both beat registers, restores
//   the register defaults and returns the connection state to its start.
// When out_ready is low, the result holds and in_ready drops once the input
//   register is also full.
// ---------------------------------------------------------------------------
module constant_rate_request_pacer #(
  parameter int TIME_BITS  = 48,
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // event channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [crrp_pkg::TIME_W-1:0]       in_now_us,
  input  logic [crrp_pkg::STATUS_W-1:0]     in_resp_status,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [crrp_pkg::TIME_W-1:0]       out_wait_us,
  output logic                              out_go_ahead,
  output logic [crrp_pkg::TIME_W-1:0]       out_corrected_latency,
  output logic [crrp_pkg::TIME_W-1:0]       out_uncorrected_latency,
  output logic                              out_latency_valid,
  output logic                              out_latency_negative,
  output logic                              out_status_error,
  output logic                              out_batch_done,
  // register writes
  input  logic                              cfg_wr_en,
  input  logic [crrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crrp_pkg::IV_W-1:0]         cfg_wdata
);
  import crrp_pkg::*;

  localparam int PW = COUNT_BITS + IV_W;

  cfg_t    cfg_r, cfg_nxt;
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r, s1_item_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;

  logic                       out_free;
  logic                       fire;
  logic                       in_fire;
  logic                       recalc_start;
  recalc_stat_t               recalc_stat;
  logic [2:0][PW-1:0]         recalc_prod;
  logic [2:0][COUNT_BITS-1:0] counts;
  result_t                    core_res;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RATE_ENABLED:   cfg_nxt.rate_enabled   = cfg_wdata[0];
        CFG_SEND_INTERVAL:  cfg_nxt.send_interval  = cfg_wdata;
        CFG_PIPELINE_DEPTH: cfg_nxt.pipeline_depth = cfg_wdata[DEPTH_W-1:0];
        CFG_RECORD_ALL:     cfg_nxt.record_all     = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign recalc_start = cfg_wr_en && (cfg_index == CFG_SEND_INTERVAL);

  // beat flow: input register, then result register
  assign out_free = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && out_free;
  assign in_ready = !recalc_stat.busy && (!s1_valid_r || out_free);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_item_nxt   = s1_item_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = core_res;
      s1_valid_nxt  = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = '{req_type: in_req_type, now_us: in_now_us, resp_status: in_resp_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{rate_enabled: 1'b0, send_interval: IV_RESET,
                       pipeline_depth: DEPTH_RESET, record_all: 1'b1};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  crrp_recalc #(
    .COUNT_BITS (COUNT_BITS)
  ) u_recalc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (recalc_start),
    .mcand_in (cfg_wdata),
    .cnt_in   (counts),
    .stat     (recalc_stat),
    .prod     (recalc_prod)
  );

  crrp_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (s1_item_r),
    .cfg         (cfg_r),
    .recalc_stat (recalc_stat),
    .recalc_prod (recalc_prod),
    .counts      (counts),
    .res         (core_res)
  );

  // result ports
  assign out_valid               = out_valid_r;
  assign out_wait_us             = out_res_r.wait_us;
  assign out_go_ahead            = out_res_r.go_ahead;
  assign out_corrected_latency   = out_res_r.corrected_latency;
  assign out_uncorrected_latency = out_res_r.uncorrected_latency;
  assign out_latency_valid       = out_res_r.latency_valid;
  assign out_latency_negative    = out_res_r.latency_negative;
  assign out_status_error        = out_res_r.status_error;
  assign out_batch_done          = out_res_r.batch_done;

endmodule
